/* rtl/sdes_pkg.sv */
// Constants, tables and bit permutation helpers for the simplified DES block.
package sdes_pkg;

    typedef logic [3:0] t_pos;
    typedef logic [1:0] t_sval;

    localparam logic FUNC_ENCRYPT = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    // Position 1 is the most significant bit of the source word.
    localparam t_pos P10[10]  = '{4'd3, 4'd5, 4'd2, 4'd7, 4'd4, 4'd10, 4'd1, 4'd9, 4'd8, 4'd6};
    localparam t_pos P8[8]    = '{4'd6, 4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9};
    localparam t_pos IP[8]    = '{4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5, 4'd7};
    localparam t_pos IP_INV[8] = '{4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8, 4'd6};
    localparam t_pos EP[8]    = '{4'd4, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd1};
    localparam t_pos P4[4]    = '{4'd2, 4'd4, 4'd3, 4'd1};

    localparam t_sval S0[4][4] = '{
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd3, 2'd2, 2'd1, 2'd0},
        '{2'd0, 2'd2, 2'd1, 2'd3},
        '{2'd3, 2'd1, 2'd3, 2'd2}
    };

    localparam t_sval S1[4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd2, 2'd0, 2'd1, 2'd3},
        '{2'd3, 2'd0, 2'd1, 2'd0},
        '{2'd2, 2'd1, 2'd0, 2'd3}
    };

    function automatic logic [9:0] f_p10(input logic [9:0] src);
        logic [9:0] res;
        for (int i = 0; i < 10; i++) begin
            res[9 - i] = src[10 - int'(P10[i])];
        end
        return res;
    endfunction

    function automatic logic [7:0] f_p8(input logic [9:0] src);
        logic [7:0] res;
        for (int i = 0; i < 8; i++) begin
            res[7 - i] = src[10 - int'(P8[i])];
        end
        return res;
    endfunction

    function automatic logic [7:0] f_ip(input logic [7:0] src);
        logic [7:0] res;
        for (int i = 0; i < 8; i++) begin
            res[7 - i] = src[8 - int'(IP[i])];
        end
        return res;
    endfunction

    function automatic logic [7:0] f_ip_inv(input logic [7:0] src);
        logic [7:0] res;
        for (int i = 0; i < 8; i++) begin
            res[7 - i] = src[8 - int'(IP_INV[i])];
        end
        return res;
    endfunction

    function automatic logic [7:0] f_ep(input logic [3:0] src);
        logic [7:0] res;
        for (int i = 0; i < 8; i++) begin
            res[7 - i] = src[4 - int'(EP[i])];
        end
        return res;
    endfunction

    function automatic logic [3:0] f_p4(input logic [3:0] src);
        logic [3:0] res;
        for (int i = 0; i < 4; i++) begin
            res[3 - i] = src[4 - int'(P4[i])];
        end
        return res;
    endfunction

    function automatic logic [4:0] f_rot1(input logic [4:0] h);
        return {h[3:0], h[4]};
    endfunction

    function automatic logic [4:0] f_rot2(input logic [4:0] h);
        return {h[2:0], h[4:3]};
    endfunction

endpackage

/* rtl/sdes_round.sv */
// One Feistel round function: expand, mix in the subkey, S-box lookup and P4.
module sdes_round import sdes_pkg::*; (
    input  logic [3:0] i_half,
    input  logic [7:0] i_subkey,
    output logic [3:0] o_mix
);

    logic [7:0] x;
    logic [3:0] a;
    logic [3:0] b;
    logic [1:0] row_a;
    logic [1:0] col_a;
    logic [1:0] row_b;
    logic [1:0] col_b;
    logic [3:0] sbox_out;

    always_comb begin
        x        = f_ep(i_half) ^ i_subkey;
        a        = x[7:4];
        b        = x[3:0];
        // outer bits pick the row, inner bits the column
        row_a    = {a[3], a[0]};
        col_a    = {a[2], a[1]};
        row_b    = {b[3], b[0]};
        col_b    = {b[2], b[1]};
        sbox_out = {S0[row_a][col_a], S1[row_b][col_b]};
        o_mix    = f_p4(sbox_out);
    end

endmodule

/* rtl/simplified_des_cipher.sv */
// Top level of the simplified DES block: key schedule, two rounds and the handshake.
//
// Usage:
//   Input channel: i_valid / o_ready carry one beat of i_func (0 encrypt,
//   1 decrypt) and the 8-bit block i_data_in. Output channel: o_valid / i_ready
//   carry one beat of o_data_out per input beat, in order.
//   The 10-bit key is written through i_cfg_wr_en / i_cipher_key; the two round
//   keys are derived at the write and held, so write the key only while no
//   block is in flight.
//   Path: an accepted beat passes the input register, then the result register,
//   to o_data_out. Throughput: one block per cycle while i_ready stays high;
//   the whole cipher is a single pass of logic between the two registers.
//   Stalls: when i_ready is low the result register holds its beat; the input
//   register still takes one more beat, and o_ready drops only when both
//   registers are full and the receiver stalls.
//   Reset (i_rst_n low, synchronous): both registers empty and the key, with
//   both round keys, is zero.
module simplified_des_cipher import sdes_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [9:0] i_cipher_key,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_func,
    input  logic [7:0] i_data_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data_out
);

    logic [7:0] r_k1;
    logic [7:0] r_k2;
    logic [7:0] n_k1;
    logic [7:0] n_k2;
    logic [9:0] key_p10;
    logic [4:0] key_hi;
    logic [4:0] key_lo;

    logic       r_in_valid;
    logic       r_func;
    logic [7:0] r_data;
    logic       r_out_valid;
    logic [7:0] r_data_out;
    logic [7:0] n_data_out;

    logic       out_free;
    logic       in_free;

    logic [7:0] ip;
    logic [7:0] key_first;
    logic [7:0] key_second;
    logic [3:0] mix_first;
    logic [3:0] mix_second;
    logic [3:0] half_one;
    logic [3:0] half_two;

    // Round key schedule from the value being written
    always_comb begin
        key_p10 = f_p10(i_cipher_key);
        key_hi  = f_rot1(key_p10[9:5]);
        key_lo  = f_rot1(key_p10[4:0]);
        n_k1    = f_p8({key_hi, key_lo});
        n_k2    = f_p8({f_rot2(key_hi), f_rot2(key_lo)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1 <= '0;
            r_k2 <= '0;
        end else if (i_cfg_wr_en) begin
            r_k1 <= n_k1;
            r_k2 <= n_k2;
        end
    end

    assign out_free = !r_out_valid || i_ready;
    assign in_free  = !r_in_valid || out_free;
    assign o_ready  = in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_valid) begin
            r_func <= i_func;
            r_data <= i_data_in;
        end
    end

    always_comb begin
        ip         = f_ip(r_data);
        key_first  = (r_func == FUNC_DECRYPT) ? r_k2 : r_k1;
        key_second = (r_func == FUNC_DECRYPT) ? r_k1 : r_k2;
    end

    sdes_round u_round_first (
        .i_half   (ip[3:0]),
        .i_subkey (key_first),
        .o_mix    (mix_first)
    );

    assign half_one = ip[7:4] ^ mix_first;

    sdes_round u_round_second (
        .i_half   (half_one),
        .i_subkey (key_second),
        .o_mix    (mix_second)
    );

    // Halves swap after the first round only
    assign half_two   = ip[3:0] ^ mix_second;
    assign n_data_out = f_ip_inv({half_two, half_one});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid) begin
            r_data_out <= n_data_out;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_data_out = r_data_out;

    a_accept_fills_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_in_valid)
        else $error("accepted beat did not reach the input register");

    a_input_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_free) |=> o_valid)
        else $error("input beat did not advance to the result register");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_valid && r_out_valid && !i_ready))
        else $error("input stalled while a register was free");

    a_key_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> (r_k1 == $past(n_k1) && r_k2 == $past(n_k2)))
        else $error("round keys not updated on key write");

endmodule

/* test/simplified_des_cipher_tb.sv */
// Self-checking testbench for the simplified DES block: directed vectors, then random traffic.
`timescale 1ns / 1ps

module simplified_des_cipher_tb import sdes_pkg::*;;

    localparam int RandomPhases   = 8;
    localparam int BlocksPerPhase = 100;
    localparam int LongHoldCycles = 80;

    typedef struct packed {
        logic [9:0] key;
        logic       func;
        logic [7:0] blk;
        logic       typed;
        logic [7:0] want;
    } t_cipher_row;

    // Typed results are the textbook S-DES vector for key 1010000010.
    localparam t_cipher_row DIRECTED_ROWS [16] = '{
        '{10'h000, FUNC_ENCRYPT, 8'h00, 1'b0, 8'h00},
        '{10'h000, FUNC_ENCRYPT, 8'hFF, 1'b0, 8'h00},
        '{10'h000, FUNC_DECRYPT, 8'h00, 1'b0, 8'h00},
        '{10'h000, FUNC_DECRYPT, 8'hFF, 1'b0, 8'h00},
        '{10'h282, FUNC_ENCRYPT, 8'h72, 1'b1, 8'h77},
        '{10'h282, FUNC_DECRYPT, 8'h77, 1'b1, 8'h72},
        '{10'h282, FUNC_ENCRYPT, 8'h01, 1'b0, 8'h00},
        '{10'h282, FUNC_DECRYPT, 8'h80, 1'b0, 8'h00},
        '{10'h3FF, FUNC_ENCRYPT, 8'h00, 1'b0, 8'h00},
        '{10'h3FF, FUNC_ENCRYPT, 8'hFF, 1'b0, 8'h00},
        '{10'h3FF, FUNC_DECRYPT, 8'h00, 1'b0, 8'h00},
        '{10'h3FF, FUNC_DECRYPT, 8'hFF, 1'b0, 8'h00},
        '{10'h200, FUNC_ENCRYPT, 8'h80, 1'b0, 8'h00},
        '{10'h200, FUNC_DECRYPT, 8'h01, 1'b0, 8'h00},
        '{10'h001, FUNC_ENCRYPT, 8'h55, 1'b0, 8'h00},
        '{10'h001, FUNC_DECRYPT, 8'hAA, 1'b0, 8'h00}
    };

    localparam logic [1:0] SBOX_LEFT [4][4] = '{
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd3, 2'd2, 2'd1, 2'd0},
        '{2'd0, 2'd2, 2'd1, 2'd3},
        '{2'd3, 2'd1, 2'd3, 2'd2}
    };

    localparam logic [1:0] SBOX_RIGHT [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd2, 2'd0, 2'd1, 2'd3},
        '{2'd3, 2'd0, 2'd1, 2'd0},
        '{2'd2, 2'd1, 2'd0, 2'd3}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [9:0] i_cipher_key;
    logic       i_valid;
    logic       o_ready;
    logic       i_func;
    logic [7:0] i_data_in;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_data_out;

    // Known result riding along with the beat on the input side.
    logic       beat_typed;
    logic [7:0] beat_want;

    logic [7:0] pending_blocks[$];
    logic [9:0] cipher_key_model;
    logic [7:0] oldest_block;
    int         mismatch_count = 0;
    int         burst_left = 0;
    int         rx_cycle = 0;
    bit         hold_req = 1'b0;
    bit         hold_active = 1'b0;

    simplified_des_cipher i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cipher_key (i_cipher_key),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_data_in    (i_data_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data_out   (o_data_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [7:0] compress_key(input logic [4:0] hi, input logic [4:0] lo);
        logic [9:0] w;
        w = {hi, lo};
        return {w[4], w[7], w[3], w[6], w[2], w[5], w[0], w[1]};
    endfunction

    // Returns {K1, K2}.
    function automatic logic [15:0] round_keys(input logic [9:0] k);
        logic [9:0] p;
        logic [4:0] hi, lo;
        logic [7:0] k1;
        p  = {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
        hi = {p[8:5], p[9]};
        lo = {p[3:0], p[4]};
        k1 = compress_key(hi, lo);
        hi = {hi[2:0], hi[4:3]};
        lo = {lo[2:0], lo[4:3]};
        return {k1, compress_key(hi, lo)};
    endfunction

    function automatic logic [3:0] feistel_mix(input logic [3:0] r, input logic [7:0] sub);
        logic [7:0] x;
        logic [3:0] s;
        x = {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]} ^ sub;
        s = {SBOX_LEFT[{x[7], x[4]}][{x[6], x[5]}], SBOX_RIGHT[{x[3], x[0]}][{x[2], x[1]}]};
        return {s[2], s[0], s[1], s[3]};
    endfunction

    function automatic logic [7:0] sdes_block(input logic [9:0] key, input logic func,
                                              input logic [7:0] blk);
        logic [15:0] rk;
        logic [7:0]  first, second, ip, x;
        logic [3:0]  lh, rh, t;
        rk     = round_keys(key);
        first  = (func == FUNC_DECRYPT) ? rk[7:0] : rk[15:8];
        second = (func == FUNC_DECRYPT) ? rk[15:8] : rk[7:0];
        ip = {blk[6], blk[2], blk[5], blk[7], blk[4], blk[0], blk[3], blk[1]};
        lh = ip[7:4];
        rh = ip[3:0];
        t  = lh ^ feistel_mix(rh, first);
        lh = rh;
        rh = t;
        t  = lh ^ feistel_mix(rh, second);
        lh = rh;
        rh = t;
        x  = {rh, lh};
        return {x[4], x[7], x[5], x[3], x[1], x[6], x[0], x[2]};
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    // Predict on every accepted input beat, check every accepted output beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cipher_key_model = '0;
        end else begin
            if (i_cfg_wr_en) cipher_key_model = i_cipher_key;
            if (i_valid && o_ready) begin
                pending_blocks.push_back(beat_typed ? beat_want
                                         : sdes_block(cipher_key_model, i_func, i_data_in));
            end
            if (o_valid && i_ready) begin
                if (pending_blocks.size() == 0) begin
                    note_failure($sformatf("unexpected output beat 0x%02h", o_data_out));
                end else begin
                    oldest_block = pending_blocks.pop_front();
                    if (o_data_out !== oldest_block) begin
                        note_failure($sformatf("data_out mismatch: expected 0x%02h, got 0x%02h",
                                               oldest_block, o_data_out));
                    end
                end
            end
        end
    end

    // Receiver: rotating stall pattern, plus one long hold on request.
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (hold_req) begin
                hold_active = 1'b1;
                hold_req    = 1'b0;
                i_ready <= 1'b0;
                repeat (LongHoldCycles) @(posedge i_clk);
                hold_active = 1'b0;
            end else begin
                case ((rx_cycle / 150) % 4)
                    0: begin
                        i_ready <= 1'b1;
                    end
                    1: begin
                        i_ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        i_ready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        i_ready <= ($urandom_range(0, 9) != 0);
                    end
                endcase
            end
        end
    end

    // Offer one beat and hold it until taken; open a gap between bursts.
    task automatic offer_block(input logic func, input logic [7:0] blk,
                               input logic typed, input logic [7:0] want);
        int gap;
        if (burst_left == 0 && !hold_req && !hold_active) begin
            gap = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        i_valid    <= 1'b1;
        i_func     <= func;
        i_data_in  <= blk;
        beat_typed <= typed;
        beat_want  <= want;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_key(input logic [9:0] key);
        i_cfg_wr_en  <= 1'b1;
        i_cipher_key <= key;
        @(posedge i_clk);
        i_cfg_wr_en  <= 1'b0;
    endtask

    initial begin
        logic [9:0] active_key;
        logic [9:0] phase_key;
        i_rst_n      <= 1'b0;
        i_cfg_wr_en  <= 1'b0;
        i_cipher_key <= '0;
        i_valid      <= 1'b0;
        i_func       <= FUNC_ENCRYPT;
        i_data_in    <= '0;
        beat_typed   <= 1'b0;
        beat_want    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Leading rows run on the reset key.
        active_key = '0;
        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].key != active_key) begin
                wait_drained();
                load_key(DIRECTED_ROWS[i].key);
                active_key = DIRECTED_ROWS[i].key;
            end
            offer_block(DIRECTED_ROWS[i].func, DIRECTED_ROWS[i].blk,
                        DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end

        for (int ph = 0; ph < RandomPhases; ph++) begin
            wait_drained();
            phase_key = (ph == 0) ? 10'h3FF : (ph == 1) ? 10'h000
                      : 10'($urandom_range(0, 1023));
            load_key(phase_key);
            for (int n = 0; n < BlocksPerPhase; n++) begin
                // Starve the output for a while so the input side backs up.
                if (ph == 3 && n == 20) hold_req = 1'b1;
                // Pause the input until every result is out.
                if (ph == 5 && n == 50) wait_drained();
                offer_block(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, 8'h00);
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
